FILE: hdl/ypfp_pkg.sv
// Shared types, constants and saturation helpers for the Yeoh stress pipeline.
`default_nettype none

package ypfp_pkg;

    localparam int NF = 9;
    localparam int CBRT_STEPS = 27;
    localparam int CBRT_NW = 3 * CBRT_STEPS;
    localparam int CBRT_RW = 60;

    localparam logic signed [31:0] Q_ONE   = 32'sd65536;
    localparam logic signed [31:0] Q_THREE = 32'sd196608;
    localparam logic signed [31:0] S32_MAX = 32'sh7fffffff;
    localparam logic signed [31:0] S32_MIN = 32'sh80000000;

    // Cofactor minors: cof[i] = f[MA]*f[MB] - f[MC]*f[MD]
    localparam int MA [NF] = '{4, 5, 3, 2, 0, 1, 1, 2, 0};
    localparam int MB [NF] = '{8, 6, 7, 7, 8, 6, 5, 3, 4};
    localparam int MC [NF] = '{5, 3, 4, 1, 2, 0, 2, 0, 1};
    localparam int MD [NF] = '{7, 8, 6, 8, 6, 7, 4, 5, 3};

    typedef enum logic [1:0] {
        CFG_C10 = 2'd0,
        CFG_C20 = 2'd1,
        CFG_C30 = 2'd2,
        CFG_D1  = 2'd3
    } t_cfg_idx;

    typedef struct packed {
        logic [NF-1:0][31:0] f;
        logic [NF-1:0][31:0] cof;
        logic [31:0]         i1;
        logic [31:0]         j;
        logic [32:0]         j3;
        logic [26:0]         t;
        logic [31:0]         g;
    } t_ctx;

    function automatic logic signed [31:0] sat32(input logic signed [63:0] x);
        if (x > 64'sd2147483647) begin
            return S32_MAX;
        end else if (x < -64'sd2147483648) begin
            return S32_MIN;
        end
        return x[31:0];
    endfunction

    function automatic logic [31:0] abs32(input logic [31:0] x);
        return x[31] ? (32'd0 - x) : x;
    endfunction

endpackage

`default_nettype wire

FILE: hdl/ypfp_div.sv
// Pipelined restoring divider, one quotient bit per stage, with overflow flag.
`default_nettype none

module ypfp_div #(
    parameter int NW = 47,
    parameter int DW = 27,
    parameter int QW = 31
) (
    input  logic          i_clk,
    input  logic          i_ce,
    input  logic [NW-1:0] i_num,
    input  logic [DW-1:0] i_den,
    output logic [QW-1:0] o_quo,
    output logic          o_ovf,
    output logic          o_rnz
);

    localparam int CW = (NW > DW + QW) ? NW : DW + QW;

    logic [NW-1:0] r_rem [QW];
    logic [QW-1:0] r_quo [QW];
    logic [DW-1:0] r_den [QW];
    logic          r_ovf [QW];

    for (genvar k = 0; k < QW; k++) begin : g_stg
        logic [NW-1:0] w_rem;
        logic [QW-1:0] w_quo;
        logic [DW-1:0] w_den;
        logic          w_ovf;
        logic [CW-1:0] w_sub;

        if (k == 0) begin : g_first
            assign w_rem = i_num;
            assign w_quo = '0;
            assign w_den = i_den;
            // quotient would not fit in QW bits
            assign w_ovf = CW'(i_num) >= (CW'(i_den) << QW);
        end else begin : g_next
            assign w_rem = r_rem[k-1];
            assign w_quo = r_quo[k-1];
            assign w_den = r_den[k-1];
            assign w_ovf = r_ovf[k-1];
        end

        assign w_sub = CW'(w_den) << (QW - 1 - k);

        always_ff @(posedge i_clk) begin
            if (i_ce) begin
                r_den[k] <= w_den;
                r_ovf[k] <= w_ovf;
                if (CW'(w_rem) >= w_sub) begin
                    r_rem[k] <= NW'(CW'(w_rem) - w_sub);
                    r_quo[k] <= w_quo | (QW'(1) << (QW - 1 - k));
                end else begin
                    r_rem[k] <= w_rem;
                    r_quo[k] <= w_quo;
                end
            end
        end
    end

    assign o_quo = r_quo[QW-1];
    assign o_ovf = r_ovf[QW-1];
    assign o_rnz = |r_rem[QW-1];

endmodule

`default_nettype wire

FILE: hdl/yeoh_first_piola_stress.sv
// Yeoh hyperelastic first Piola-Kirchhoff stress: streaming pipeline, top level.
//
//  channel   direction  handshake                 payload
//  s         in         i_s_tvalid / o_s_tready   i_s_tdata: f00..f22
//  m         out        o_m_tvalid / i_m_tready   o_m_tdata: p00..p22, o_m_tuser: invalid
//  cfg       in         i_cfg_valid / o_cfg_ready i_cfg_index, i_cfg_data
//
// One transaction per cycle while the output is not stalled; the path from input to the
// output register runs through the 27-step cube root and two 31-step dividers in series.
// Reset clears the valid bits and output/skid valid flags, zeroes C10..C30, sets D1 to 65536.
// A stalled output fills the skid register; the pipe then holds until it drains.
// Config is always ready and is applied at once.
`default_nettype none

module yeoh_first_piola_stress (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_s_tvalid,
    output logic               o_s_tready,
    input  logic [287:0]       i_s_tdata,    // f00,f01,f02,f10,f11,f12,f20,f21,f22 (32b each)
    output logic               o_m_tvalid,
    input  logic               i_m_tready,
    output logic [287:0]       o_m_tdata,    // p00,p01,p02,p10,p11,p12,p20,p21,p22 (32b each)
    output logic [0:0]         o_m_tuser,    // invalid
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  ypfp_pkg::t_cfg_idx i_cfg_index,
    input  logic [30:0]        i_cfg_data
);

    import ypfp_pkg::*;

    localparam int DIV_Q    = 31;
    localparam int DIV_FQ   = 47;
    localparam int IX_CB    = CBRT_STEPS + 1;
    localparam int IX_T     = IX_CB + 1;
    localparam int IX_I1B   = IX_CB + DIV_Q;
    localparam int IX_G     = IX_I1B + 5;
    localparam int IX_DONE  = IX_I1B + DIV_Q;
    localparam int IX_FDIV  = IX_DONE - DIV_FQ;
    localparam int CTX_LEN  = IX_DONE + 4;
    localparam int PIPE_LEN = IX_DONE + 10;

    // configuration
    logic [30:0] r_c10, r_c20, r_c30, r_d1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_c10 <= '0;
            r_c20 <= '0;
            r_c30 <= '0;
            r_d1  <= 31'd65536;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_C10: r_c10 <= i_cfg_data;
                CFG_C20: r_c20 <= i_cfg_data;
                CFG_C30: r_c30 <= i_cfg_data;
                CFG_D1:  r_d1  <= i_cfg_data;
            endcase
        end
    end

    assign o_cfg_ready = 1'b1;

    // pipeline control
    logic                r_skid_v, r_out_v;
    logic                w_ce;
    logic [PIPE_LEN-1:0] r_vld;

    assign w_ce       = !r_skid_v;
    assign o_s_tready = w_ce;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (w_ce) begin
            r_vld <= {r_vld[PIPE_LEN-2:0], i_s_tvalid};
        end
    end

    // front: minors, squares, determinant
    logic [NF-1:0][31:0] r_f, r_f2, r_f3, r_f4;
    logic signed [63:0]  r_pm [2*NF];
    logic signed [63:0]  r_sq [NF];
    logic [NF-1:0][31:0] r_cof, r_cof4;
    logic [31:0]         r_i1, r_i1_4;
    logic signed [63:0]  r_jp [3];
    logic signed [63:0]  w_i1s;
    logic signed [31:0]  w_j;

    always_ff @(posedge i_clk) begin
        if (w_ce) begin
            r_f    <= i_s_tdata;
            r_f2   <= r_f;
            r_f3   <= r_f2;
            r_f4   <= r_f3;
            r_i1   <= w_i1s[31:0];
            r_i1_4 <= r_i1;
            r_cof4 <= r_cof;
        end
    end

    for (genvar i = 0; i < NF; i++) begin : g_front
        always_ff @(posedge i_clk) begin
            if (w_ce) begin
                r_pm[2*i]   <= $signed(r_f[MA[i]]) * $signed(r_f[MB[i]]);
                r_pm[2*i+1] <= $signed(r_f[MC[i]]) * $signed(r_f[MD[i]]);
                r_sq[i]     <= $signed(r_f[i]) * $signed(r_f[i]);
                r_cof[i]    <= sat32((r_pm[2*i] - r_pm[2*i+1]) >>> 16);
            end
        end
    end

    always_comb begin
        w_i1s = '0;
        for (int i = 0; i < NF; i++) begin
            w_i1s = w_i1s + (r_sq[i] >>> 16);
        end
        w_i1s = 64'(sat32(w_i1s));
    end

    for (genvar i = 0; i < 3; i++) begin : g_jp
        always_ff @(posedge i_clk) begin
            if (w_ce) begin
                r_jp[i] <= $signed(r_f3[i]) * $signed(r_cof[i]);
            end
        end
    end

    assign w_j = sat32((r_jp[0] >>> 16) + (r_jp[1] >>> 16) + (r_jp[2] >>> 16));

    // context line
    t_ctx        r_ctx [CTX_LEN];
    logic [26:0] w_t;
    logic [31:0] w_g;

    always_ff @(posedge i_clk) begin
        if (w_ce) begin
            r_ctx[0] <= '{f: r_f4, cof: r_cof4, i1: r_i1_4, j: w_j,
                          j3: 33'(w_j[30:0]) + (33'(w_j[30:0]) << 1), t: '0, g: '0};
        end
    end

    for (genvar k = 1; k < CTX_LEN; k++) begin : g_ctx
        t_ctx n_ctx;

        // pick up t and g at their stages
        always_comb begin
            n_ctx = r_ctx[k-1];
            if (k == IX_T) begin
                n_ctx.t = w_t;
            end
            if (k == IX_G) begin
                n_ctx.g = w_g;
            end
        end

        always_ff @(posedge i_clk) begin
            if (w_ce) begin
                r_ctx[k] <= n_ctx;
            end
        end
    end

    // cube root of J^2 * 2^16, three radicand bits per stage
    logic [61:0]        w_jj;
    logic [CBRT_NW-1:0] r_n;
    logic [CBRT_NW-1:0] r_cn [CBRT_STEPS];
    logic [26:0]        r_cy [CBRT_STEPS];
    logic [53:0]        r_cs [CBRT_STEPS];
    logic [CBRT_RW-1:0] r_cr [CBRT_STEPS];

    assign w_jj = r_ctx[0].j[30:0] * r_ctx[0].j[30:0];

    always_ff @(posedge i_clk) begin
        if (w_ce) begin
            r_n <= CBRT_NW'({w_jj, 16'd0});
        end
    end

    for (genvar m = 0; m < CBRT_STEPS; m++) begin : g_cbrt
        logic [CBRT_NW-1:0] w_nn;
        logic [26:0]        w_y;
        logic [53:0]        w_s;
        logic [CBRT_RW-1:0] w_rp, w_r, w_tr;

        if (m == 0) begin : g_first
            assign w_nn = r_n;
            assign w_y  = '0;
            assign w_s  = '0;
            assign w_rp = '0;
        end else begin : g_next
            assign w_nn = r_cn[m-1];
            assign w_y  = r_cy[m-1];
            assign w_s  = r_cs[m-1];
            assign w_rp = r_cr[m-1];
        end

        assign w_r  = {w_rp[CBRT_RW-4:0], w_nn[CBRT_NW-1-3*m -: 3]};
        // trial = 3(2y)^2 + 3(2y) + 1
        assign w_tr = (CBRT_RW'(w_s) << 3) + (CBRT_RW'(w_s) << 2)
                    + (CBRT_RW'(w_y) << 2) + (CBRT_RW'(w_y) << 1) + CBRT_RW'(1);

        always_ff @(posedge i_clk) begin
            if (w_ce) begin
                r_cn[m] <= w_nn;
                if (w_r >= w_tr) begin
                    r_cr[m] <= w_r - w_tr;
                    r_cy[m] <= {w_y[25:0], 1'b1};
                    r_cs[m] <= (w_s << 2) + (54'(w_y) << 2) + 54'd1;
                end else begin
                    r_cr[m] <= w_r;
                    r_cy[m] <= {w_y[25:0], 1'b0};
                    r_cs[m] <= w_s << 2;
                end
            end
        end
    end

    assign w_t = r_cy[CBRT_STEPS-1];

    // I1bar = I1 / t
    logic [30:0] w_i1b_q;
    logic        w_i1b_ovf, w_i1b_rnz;
    logic [30:0] w_i1b;

    ypfp_div #(.NW(47), .DW(27), .QW(DIV_Q)) u_div_i1b (
        .i_clk (i_clk),
        .i_ce  (w_ce),
        .i_num ({r_ctx[IX_CB].i1[30:0], 16'd0}),
        .i_den (w_t),
        .o_quo (w_i1b_q),
        .o_ovf (w_i1b_ovf),
        .o_rnz (w_i1b_rnz)
    );

    assign w_i1b = w_i1b_ovf ? 31'h7fffffff : w_i1b_q;

    // k = 2 I1bar / (3 J), v = 2 (J - 1) / D1
    logic [30:0]        w_k_q, w_v_q;
    logic               w_k_ovf, w_k_rnz, w_v_ovf, w_v_rnz;
    logic signed [31:0] w_vd;
    logic [30:0]        w_d1;

    assign w_vd = $signed(r_ctx[IX_I1B].j) - Q_ONE;
    assign w_d1 = (r_d1 == '0) ? 31'd1 : r_d1;

    ypfp_div #(.NW(48), .DW(33), .QW(DIV_Q)) u_div_k (
        .i_clk (i_clk),
        .i_ce  (w_ce),
        .i_num ({w_i1b, 17'd0}),
        .i_den (r_ctx[IX_I1B].j3),
        .o_quo (w_k_q),
        .o_ovf (w_k_ovf),
        .o_rnz (w_k_rnz)
    );

    ypfp_div #(.NW(49), .DW(31), .QW(DIV_Q)) u_div_v (
        .i_clk (i_clk),
        .i_ce  (w_ce),
        .i_num ({abs32(w_vd), 17'd0}),
        .i_den (w_d1),
        .o_quo (w_v_q),
        .o_ovf (w_v_ovf),
        .o_rnz (w_v_rnz)
    );

    // 2 f / t for each entry
    logic [DIV_FQ-1:0] w_fq_q [NF];
    logic              w_fq_ovf [NF];
    logic              w_fq_rnz [NF];

    for (genvar i = 0; i < NF; i++) begin : g_fdiv
        ypfp_div #(.NW(49), .DW(27), .QW(DIV_FQ)) u_div_f (
            .i_clk (i_clk),
            .i_ce  (w_ce),
            .i_num ({abs32(r_ctx[IX_FDIV].f[i]), 17'd0}),
            .i_den (r_ctx[IX_FDIV].t),
            .o_quo (w_fq_q[i]),
            .o_ovf (w_fq_ovf[i]),
            .o_rnz (w_fq_rnz[i])
        );
    end

    // deviatoric factor g
    logic signed [31:0] r_gd, r_gd2;
    logic signed [63:0] r_gdd, r_g20, r_g20q, r_g20q4, r_g30;

    always_ff @(posedge i_clk) begin
        if (w_ce) begin
            r_gd    <= $signed({1'b0, w_i1b}) - Q_THREE;
            r_gdd   <= r_gd * r_gd;
            r_g20   <= $signed({1'b0, r_c20}) * r_gd;
            r_gd2   <= sat32(r_gdd >>> 16);
            r_g20q  <= r_g20 >>> 16;
            r_g30   <= $signed({1'b0, r_c30}) * r_gd2;
            r_g20q4 <= r_g20q;
        end
    end

    assign w_g = sat32($signed({33'd0, r_c10}) + (r_g20q4 <<< 1)
                       + ((r_g30 >>> 16) <<< 1) + (r_g30 >>> 16));

    // back end
    logic signed [31:0] r_ek, r_ev, r_ev2, r_ev3;
    logic signed [48:0] r_efq [NF];
    logic signed [48:0] r_efq2 [NF];
    logic signed [63:0] r_ekc [NF];
    logic signed [31:0] r_eq [NF];
    logic signed [63:0] r_egq [NF];
    logic signed [63:0] r_evc [NF];
    logic               r_einv, r_pinv;
    logic [NF-1:0][31:0] r_p;
    logic [31:0]        w_vm;
    logic signed [31:0] w_v;
    logic               w_vneg;

    assign w_vneg = $signed(r_ctx[IX_DONE].j) < Q_ONE;
    assign w_vm   = {1'b0, w_v_q} + 32'(w_v_rnz);

    always_comb begin
        if (!w_vneg) begin
            w_v = w_v_ovf ? S32_MAX : $signed({1'b0, w_v_q});
        end else begin
            w_v = w_v_ovf ? S32_MIN : $signed(32'd0 - w_vm);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_ce) begin
            r_ek   <= w_k_ovf ? S32_MAX : $signed({1'b0, w_k_q});
            r_ev   <= w_v;
            r_ev2  <= r_ev;
            r_ev3  <= r_ev2;
            r_einv <= $signed(r_ctx[IX_DONE+3].j) <= 32'sd0;
            r_pinv <= r_einv;
        end
    end

    for (genvar i = 0; i < NF; i++) begin : g_back
        logic        w_fneg;
        logic [48:0] w_fm;

        assign w_fneg = r_ctx[IX_DONE].f[i][31];
        assign w_fm   = {2'b0, w_fq_q[i]} + 49'(w_fq_rnz[i]);

        always_ff @(posedge i_clk) begin
            if (w_ce) begin
                if (w_fq_ovf[i]) begin
                    r_efq[i] <= w_fneg ? -49'sh800000000000 : 49'sh800000000000;
                end else begin
                    r_efq[i] <= w_fneg ? $signed(49'd0 - w_fm) : $signed({2'b0, w_fq_q[i]});
                end
                r_efq2[i] <= r_efq[i];
                r_ekc[i]  <= r_ek * $signed(r_ctx[IX_DONE+1].cof[i]);
                r_eq[i]   <= sat32(64'(r_efq2[i]) - (r_ekc[i] >>> 16));
                r_egq[i]  <= $signed(r_ctx[IX_DONE+3].g) * r_eq[i];
                r_evc[i]  <= r_ev3 * $signed(r_ctx[IX_DONE+3].cof[i]);
                r_p[i]    <= r_einv ? 32'd0 : sat32((r_egq[i] >>> 16) + (r_evc[i] >>> 16));
            end
        end
    end

    // output register and skid
    logic [287:0] r_out_d, r_skid_d;
    logic         r_out_u, r_skid_u;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v  <= 1'b0;
            r_skid_v <= 1'b0;
        end else if (r_out_v && !i_m_tready) begin
            if (w_ce && r_vld[PIPE_LEN-1]) begin
                r_skid_v <= 1'b1;
            end
        end else if (r_skid_v) begin
            r_out_v  <= 1'b1;
            r_skid_v <= 1'b0;
        end else begin
            r_out_v <= r_vld[PIPE_LEN-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_out_v && !i_m_tready) begin
            if (w_ce) begin
                r_skid_d <= r_p;
                r_skid_u <= r_pinv;
            end
        end else if (r_skid_v) begin
            r_out_d <= r_skid_d;
            r_out_u <= r_skid_u;
        end else begin
            r_out_d <= r_p;
            r_out_u <= r_pinv;
        end
    end

    assign o_m_tvalid = r_out_v;
    assign o_m_tdata  = r_out_d;
    assign o_m_tuser  = r_out_u;

`ifndef SYNTHESIS
    a_skid_needs_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_v |-> r_out_v) else $error("skid holds data while output is empty");

    a_skid_only_on_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_skid_v) |-> $past(r_out_v && !i_m_tready))
        else $error("skid filled without an output stall");

    a_invalid_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && o_m_tuser[0]) |-> (o_m_tdata == '0))
        else $error("invalid result carries nonzero stress");

    a_cfg_d1: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cfg_valid && i_cfg_index == CFG_D1) |=> (r_d1 == $past(i_cfg_data)))
        else $error("D1 write lost");
`endif

endmodule

`default_nettype wire
